// ===== rtl/sti_pkg.sv =====
// ---------------------------------------------------------------------------
// sti_pkg: shared types and constants for the sorted table
// Operation codes, cell commands, status codes and controller states.
// ---------------------------------------------------------------------------
package sti_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int OUT_COUNT_W  = 5;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_READ
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,   // open a slot at the first entry greater than key
    CELL_SQUEEZE,  // entries >= key move one place toward the head
    CELL_ROTATE    // valid entries move toward the head, head wraps to tail
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  key;
  } cell_ctrl_t;

endpackage

// ===== rtl/sti_cell.sv =====
// ---------------------------------------------------------------------------
// sti_cell: one slot of the sorted table
// Holds one entry and its valid bit, compares it with the broadcast key and
// takes data from a neighbor as the command says.
// ---------------------------------------------------------------------------
module sti_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sti_pkg::cell_ctrl_t                ctrl,
  input  logic signed [sti_pkg::VALUE_W-1:0] prev_value,
  input  logic                               prev_valid,
  input  logic                               prev_ins,
  input  logic signed [sti_pkg::VALUE_W-1:0] next_value,
  input  logic                               next_valid,
  input  logic signed [sti_pkg::VALUE_W-1:0] head_value,
  output logic signed [sti_pkg::VALUE_W-1:0] value_o,
  output logic                               valid_o,
  output logic                               ins_o,
  output logic                               eq_o
);
  import sti_pkg::*;

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic                      valid_r, valid_nxt;
  logic                      ge;

  // ins: this slot is at or past the insertion point
  assign ins_o = !valid_r || (value_r > ctrl.key);
  assign ge    = valid_r && (value_r >= ctrl.key);
  assign eq_o  = valid_r && (value_r == ctrl.key);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (prev_ins) begin
          value_nxt = prev_value;
          valid_nxt = prev_valid;
        end else if (ins_o) begin
          value_nxt = ctrl.key;
          valid_nxt = 1'b1;
        end
      end
      CELL_SQUEEZE: begin
        if (ge) begin
          value_nxt = next_value;
          valid_nxt = next_valid;
        end
      end
      CELL_ROTATE: begin
        if (valid_r) begin
          value_nxt = next_valid ? next_value : head_value;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;
  assign valid_o = valid_r;

endmodule

// ===== rtl/sorted_table_insert_remove_top.sv =====
// ---------------------------------------------------------------------------
// sorted_table_insert_remove_top: sorted multiset of signed 32-bit values
// A chain of slot cells keeps the entries in ascending order.
// ---------------------------------------------------------------------------
// Input stream: in_tuser carries the operation (insert, remove all equal,
// read out), in_tdata the value. Operation code 3 is swallowed silently.
// Output stream: one transaction per insert or remove, one per stored entry
// for a readout (a single empty-status transaction if nothing is stored);
// out_tlast marks the final transaction of each operation.
// Sequence: an insert is accepted and applied in the same cycle. A remove
// has an accepting cycle, then one cell-chain shift per removed entry, then
// a report step. A readout has an accepting cycle (which also reports when
// empty), then the chain rotates one place per emitted entry and is back in
// order at the end. Only one operation is in flight; in_tready is high only
// while idle and the output register is free or being drained. Results are
// formed into a single output register and show up in the cycle after.
// Reset clears every valid bit and the count; the table is empty at once.
// A stall on out_tready holds the output register and pauses the readout
// rotation; a remove keeps shifting and only waits for its final report.
// ---------------------------------------------------------------------------
module sorted_table_insert_remove_top #(
  parameter int CAPACITY = sti_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] entry_value, [36:32] entry_count,
                                  // [41:37] removed_count, zero above
  output logic        out_tlast,  // last
  output logic [1:0]  out_tuser   // [1:0] status
);
  import sti_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              removed_r, removed_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic signed [VALUE_W-1:0]  val_r, val_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0]  out_value_r;
  logic [OUT_COUNT_W-1:0]     out_count_r, out_removed_r;
  logic                       out_last_r;
  status_t                    out_status_r;

  logic                       load;
  logic signed [VALUE_W-1:0]  ld_value;
  logic [CW-1:0]              ld_count, ld_removed;
  logic                       ld_last;
  status_t                    ld_status;

  cell_ctrl_t                 ctrl;
  logic                       out_free, full, match_any, read_last;
  mode_t                      in_mode;

  logic signed [VALUE_W-1:0]  cell_value [CAPACITY];
  logic [CAPACITY-1:0]        cell_valid, cell_ins, cell_eq;

  assign in_mode   = mode_t'(in_tuser);
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (count_r == CW'(CAPACITY));
  assign match_any = |cell_eq;
  assign read_last = (idx_r == count_r - CW'(1));

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] pv, nv;
    logic                      pvld, pins, nvld;
    if (i == 0) begin : g_head
      assign pv   = '0;
      assign pvld = 1'b0;
      assign pins = 1'b0;
    end else begin : g_mid
      assign pv   = cell_value[i-1];
      assign pvld = cell_valid[i-1];
      assign pins = cell_ins[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign nv   = '0;
      assign nvld = 1'b0;
    end else begin : g_body
      assign nv   = cell_value[i+1];
      assign nvld = cell_valid[i+1];
    end
    sti_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_value (pv),
      .prev_valid (pvld),
      .prev_ins   (pins),
      .next_value (nv),
      .next_valid (nvld),
      .head_value (cell_value[0]),
      .value_o    (cell_value[i]),
      .valid_o    (cell_valid[i]),
      .ins_o      (cell_ins[i]),
      .eq_o       (cell_eq[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    removed_nxt = removed_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    in_tready   = 1'b0;
    ctrl.op     = CELL_HOLD;
    ctrl.key    = (state_r == ST_IDLE) ? $signed(in_tdata) : val_r;
    load        = 1'b0;
    ld_value    = '0;
    ld_count    = count_r;
    ld_removed  = '0;
    ld_last     = 1'b1;
    ld_status   = STATUS_DONE;
    case (state_r)
      ST_IDLE: begin
        in_tready = out_free;
        if (in_tvalid && out_free) begin
          case (in_mode)
            MODE_INSERT: begin
              load = 1'b1;
              if (full) begin
                ld_status = STATUS_FULL;
              end else begin
                ctrl.op   = CELL_INSERT;
                count_nxt = count_r + CW'(1);
                ld_count  = count_r + CW'(1);
              end
            end
            MODE_REMOVE: begin
              val_nxt     = $signed(in_tdata);
              removed_nxt = '0;
              state_nxt   = ST_REMOVE;
            end
            MODE_READ: begin
              if (count_r == '0) begin
                load      = 1'b1;
                ld_status = STATUS_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_REMOVE: begin
        if (match_any) begin
          ctrl.op     = CELL_SQUEEZE;
          count_nxt   = count_r - CW'(1);
          removed_nxt = removed_r + CW'(1);
        end else if (out_free) begin
          load       = 1'b1;
          ld_removed = removed_r;
          state_nxt  = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          load     = 1'b1;
          ld_value = cell_value[0];
          ld_last  = read_last;
          ctrl.op  = CELL_ROTATE;
          idx_nxt  = idx_r + CW'(1);
          if (read_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    if (load) begin
      out_value_r   <= ld_value;
      out_count_r   <= OUT_COUNT_W'(ld_count);
      out_removed_r <= OUT_COUNT_W'(ld_removed);
      out_last_r    <= ld_last;
      out_status_r  <= ld_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_removed_r, out_count_r, out_value_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  // valid bits always track the count
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("valid cells disagree with count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_mode == MODE_INSERT && !full)
      |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not add an entry");

  a_squeeze_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REMOVE && match_any) |=> count_r == $past(count_r) - CW'(1))
    else $error("remove step did not drop an entry");

endmodule
